>>> hdl/ssi_pkg.sv
`timescale 1ns / 1ps

package ssi_pkg;

  // coordinate and derived datapath widths
  localparam int CW    = 32;           // coordinate
  localparam int RADW  = CW - 1;       // radius
  localparam int VW    = CW + 1;       // coordinate differences
  localparam int PRW   = 2 * VW;       // product of two differences
  localparam int RRW   = 2 * RADW;     // radius squared
  localparam int AW    = 2 * CW + 2;   // A, unsigned
  localparam int BW    = AW + 1;       // b and C, signed
  localparam int MW    = AW;           // magnitude of b and C
  localparam int HW    = MW / 2;       // half of a magnitude
  localparam int SQW   = 2 * MW;       // b*b, A*|C|, sqrt radicand
  localparam int DW    = SQW + 2;      // discriminant, signed
  localparam int RTW   = MW;           // integer square root
  localparam int SRW   = RTW + 3;      // square root partial remainder
  localparam int NW    = RTW + 2;      // root numerator n, signed
  localparam int EW    = NW + 2;       // 2n - A, signed
  localparam int NMW   = NW - 1;       // magnitude of n
  localparam int QB    = CW + 2;       // quotient bits, larger values saturate
  localparam int PLW   = QB + VW;      // low partial product of n*v
  localparam int PHW   = NMW - QB + VW; // high partial product of n*v
  localparam int PMW   = NMW + CW;     // magnitude of n*v
  localparam int NUMW  = PMW + 3;      // 2*n*v + A, signed
  localparam int NMAGW = NUMW - 1;     // its magnitude
  localparam int NHW   = NMAGW - QB;   // numerator bits above the quotient window
  localparam int DENW  = AW + 1;       // 2A
  localparam int QW    = QB + 2;       // signed floor quotient
  localparam int SUMW  = QW + 1;       // start point plus quotient

  localparam int SQ_STAGES  = SQW / 2;
  localparam int DIV_STAGES = QB;

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_MISS    = 2'd0,
    ST_TANGENT = 2'd1,
    ST_TWO     = 2'd2,
    ST_DEGEN   = 2'd3
  } status_e;

endpackage

>>> hdl/ssi_isqrt.sv
`timescale 1ns / 1ps

// pipelined integer square root, two radicand bits per stage
module ssi_isqrt (
  input  logic                      clk_i,
  input  logic [ssi_pkg::SQW-1:0]   rad_i,
  output logic [ssi_pkg::RTW-1:0]   root_o
);

  logic [ssi_pkg::SRW-1:0] rem_q  [ssi_pkg::SQ_STAGES];
  logic [ssi_pkg::RTW-1:0] root_q [ssi_pkg::SQ_STAGES];
  logic [ssi_pkg::SQW-1:0] rad_q  [ssi_pkg::SQ_STAGES-1];

  for (genvar k = 0; k < ssi_pkg::SQ_STAGES; k++) begin : g_stage
    logic [ssi_pkg::SRW-1:0] rem_in;
    logic [ssi_pkg::SRW-1:0] tr;
    logic [ssi_pkg::SRW-1:0] trial;
    logic [ssi_pkg::RTW-1:0] root_in;
    logic [ssi_pkg::SQW-1:0] rad_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign tr    = {rem_in[ssi_pkg::SRW-3:0], rad_in[ssi_pkg::SQW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (tr >= trial) begin
        rem_q[k]  <= tr - trial;
        root_q[k] <= {root_in[ssi_pkg::RTW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= tr;
        root_q[k] <= {root_in[ssi_pkg::RTW-2:0], 1'b0};
      end
    end

    if (k < ssi_pkg::SQ_STAGES - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        rad_q[k] <= {rad_in[ssi_pkg::SQW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ssi_pkg::SQ_STAGES-1];

endmodule

>>> hdl/ssi_div.sv
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
// num_hi_i must be below den_i
module ssi_div (
  input  logic                        clk_i,
  input  logic [ssi_pkg::NHW-1:0]     num_hi_i,
  input  logic [ssi_pkg::QB-1:0]      num_lo_i,
  input  logic [ssi_pkg::DENW-1:0]    den_i,
  output logic [ssi_pkg::QB-1:0]      quo_o,
  output logic                        rem_nz_o
);

  logic [ssi_pkg::DENW-1:0] rem_q [ssi_pkg::DIV_STAGES];
  logic [ssi_pkg::QB-1:0]   lo_q  [ssi_pkg::DIV_STAGES];
  logic [ssi_pkg::DENW-1:0] den_q [ssi_pkg::DIV_STAGES-1];

  for (genvar k = 0; k < ssi_pkg::DIV_STAGES; k++) begin : g_stage
    logic [ssi_pkg::DENW-1:0] rem_in;
    logic [ssi_pkg::QB-1:0]   lo_in;
    logic [ssi_pkg::DENW-1:0] den_in;
    logic [ssi_pkg::DENW:0]   tr;
    logic [ssi_pkg::DENW:0]   diff;
    logic                     ge;

    if (k == 0) begin : g_first
      assign rem_in = ssi_pkg::DENW'(num_hi_i);
      assign lo_in  = num_lo_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
    end

    // lo holds the unused numerator bits on top and the quotient bits below
    assign tr   = {rem_in, lo_in[ssi_pkg::QB-1]};
    assign diff = tr - {1'b0, den_in};
    assign ge   = (tr >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[ssi_pkg::DENW-1:0] : tr[ssi_pkg::DENW-1:0];
      lo_q[k]  <= {lo_in[ssi_pkg::QB-2:0], ge};
    end

    if (k < ssi_pkg::DIV_STAGES - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o    = lo_q[ssi_pkg::DIV_STAGES-1];
  assign rem_nz_o = (rem_q[ssi_pkg::DIV_STAGES-1] != '0);

endmodule

>>> hdl/segment_sphere_intersection.sv
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// query     in         start high, busy low           start_*, end_*, center_*, radius_i
// result    out        done_o high for one cycle      hit_*_o, status_o, saturated_o
//
// fully pipelined: one query accepted every cycle, busy is never raised
// the pipeline depth is dominated by the 66-stage square root
// and the 34-stage divider, each resolving one result bit per stage
// reset clears only the valid bits; data registers load freely
// results cannot be held off, so the pipeline never stalls
module segment_sphere_intersection (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ssi_pkg::CW-1:0]     start_x_i,
  input  logic signed [ssi_pkg::CW-1:0]     start_y_i,
  input  logic signed [ssi_pkg::CW-1:0]     start_z_i,
  input  logic signed [ssi_pkg::CW-1:0]     end_x_i,
  input  logic signed [ssi_pkg::CW-1:0]     end_y_i,
  input  logic signed [ssi_pkg::CW-1:0]     end_z_i,
  input  logic signed [ssi_pkg::CW-1:0]     center_x_i,
  input  logic signed [ssi_pkg::CW-1:0]     center_y_i,
  input  logic signed [ssi_pkg::CW-1:0]     center_z_i,
  input  logic        [ssi_pkg::RADW-1:0]   radius_i,
  output logic                              done_o,
  output logic signed [ssi_pkg::CW-1:0]     hit_x_o,
  output logic signed [ssi_pkg::CW-1:0]     hit_y_o,
  output logic signed [ssi_pkg::CW-1:0]     hit_z_o,
  output logic        [1:0]                 status_o,
  output logic                              saturated_o
);

  // side data riding along the square root
  typedef struct packed {
    logic [ssi_pkg::AW-1:0]         a;
    logic [ssi_pkg::BW-1:0]         b;
    logic [2:0][ssi_pkg::CW-1:0]    s;
    logic [2:0][ssi_pkg::VW-1:0]    v;
    ssi_pkg::status_e               st;
  } sq_side_t;

  // side data of the root selection stages
  typedef struct packed {
    logic [ssi_pkg::AW-1:0]         a;
    logic [2:0][ssi_pkg::CW-1:0]    s;
    logic [2:0][ssi_pkg::VW-1:0]    v;
    ssi_pkg::status_e               st;
  } tail_t;

  // side data riding along the dividers
  typedef struct packed {
    logic [2:0][ssi_pkg::CW-1:0]    s;
    ssi_pkg::status_e               st;
    logic [2:0]                     neg;
    logic [2:0]                     big;
  } dv_side_t;

  logic [2:0][ssi_pkg::CW-1:0] in_s, in_e, in_c;

  // stage 1: differences
  logic                          s1_vld_q;
  logic [2:0][ssi_pkg::CW-1:0]   s1_s_q;
  logic [2:0][ssi_pkg::VW-1:0]   s1_v_q, s1_w_q;
  logic [ssi_pkg::RADW-1:0]      s1_r_q;

  // stage 2: squares and dot product terms
  logic                          s2_vld_q;
  logic [2:0][ssi_pkg::PRW-1:0]  s2_vv_q, s2_wv_q, s2_ww_q;
  logic [ssi_pkg::RRW-1:0]       s2_rr_q;
  logic [2:0][ssi_pkg::CW-1:0]   s2_s_q;
  logic [2:0][ssi_pkg::VW-1:0]   s2_v_q;

  // stage 3: quadratic coefficients
  logic signed [ssi_pkg::PRW+1:0] a_sum, b_sum, c_sum;
  logic                          s3_vld_q;
  logic [ssi_pkg::AW-1:0]        s3_a_q;
  logic [ssi_pkg::BW-1:0]        s3_b_q, s3_c_q;
  logic [2:0][ssi_pkg::CW-1:0]   s3_s_q;
  logic [2:0][ssi_pkg::VW-1:0]   s3_v_q;

  // stage 4: partial products of b*b and A*|C|
  logic [ssi_pkg::BW-1:0]        b_abs, c_abs;
  logic [ssi_pkg::MW-1:0]        bm, cm;
  logic [ssi_pkg::HW-1:0]        a_lo, b_lo, c_lo;
  logic [ssi_pkg::MW-ssi_pkg::HW-1:0] a_hi, b_hi, c_hi;
  logic                          s4_vld_q;
  logic [ssi_pkg::PRW-1:0]       s4_bhh_q, s4_bhl_q, s4_bll_q;
  logic [ssi_pkg::PRW-1:0]       s4_ahh_q, s4_ahl_q, s4_alh_q, s4_all_q;
  logic                          s4_cneg_q, s4_azero_q;
  logic [ssi_pkg::AW-1:0]        s4_a_q;
  logic [ssi_pkg::BW-1:0]        s4_b_q;
  logic [2:0][ssi_pkg::CW-1:0]   s4_s_q;
  logic [2:0][ssi_pkg::VW-1:0]   s4_v_q;

  // stage 5: full products
  logic                          s5_vld_q;
  logic [ssi_pkg::SQW-1:0]       s5_bsq_q, s5_acm_q;
  logic                          s5_cneg_q, s5_azero_q;
  logic [ssi_pkg::AW-1:0]        s5_a_q;
  logic [ssi_pkg::BW-1:0]        s5_b_q;
  logic [2:0][ssi_pkg::CW-1:0]   s5_s_q;
  logic [2:0][ssi_pkg::VW-1:0]   s5_v_q;

  // stage 6: discriminant and case
  logic [ssi_pkg::DW-1:0]        disc;
  ssi_pkg::status_e              st_d;
  logic                          s6_vld_q;
  logic [ssi_pkg::SQW-1:0]       s6_rad_q;
  sq_side_t                      s6_side_q;

  // square root pipe
  logic [ssi_pkg::SQ_STAGES-1:0] sq_vld_q;
  sq_side_t                      sq_side_q [ssi_pkg::SQ_STAGES];
  logic [ssi_pkg::RTW-1:0]       root;
  sq_side_t                      sq_out;

  // stages 7 to 14: root choice, n*v, numerator
  logic [ssi_pkg::NW-1:0]        nb;
  logic                          s7_vld_q;
  logic [ssi_pkg::NW-1:0]        s7_n1_q, s7_n2_q;
  tail_t                         s7_tl_q;

  logic                          s8_vld_q;
  logic [ssi_pkg::EW-1:0]        s8_d1_q, s8_d2_q;
  logic [ssi_pkg::NW-1:0]        s8_n1_q, s8_n2_q;
  tail_t                         s8_tl_q;

  logic [ssi_pkg::EW-1:0]        e1, e2;
  logic                          s9_vld_q;
  logic [ssi_pkg::NW-1:0]        s9_n_q;
  tail_t                         s9_tl_q;

  logic [ssi_pkg::NW-1:0]        n_abs;
  logic [2:0][ssi_pkg::VW-1:0]   v_abs;
  logic                          s10_vld_q;
  logic [ssi_pkg::NMW-1:0]       s10_nm_q;
  logic                          s10_nneg_q;
  logic [2:0][ssi_pkg::VW-1:0]   s10_vm_q;
  logic [2:0]                    s10_vneg_q;
  tail_t                         s10_tl_q;

  logic                          s11_vld_q;
  logic [2:0][ssi_pkg::PLW-1:0]  s11_pl_q;
  logic [2:0][ssi_pkg::PHW-1:0]  s11_ph_q;
  logic [2:0]                    s11_pneg_q;
  tail_t                         s11_tl_q;

  logic                          s12_vld_q;
  logic [2:0][ssi_pkg::PMW-1:0]  s12_pm_q;
  logic [2:0]                    s12_pneg_q;
  tail_t                         s12_tl_q;

  logic [ssi_pkg::NUMW-1:0]      a_ext;
  logic [2:0][ssi_pkg::NUMW-1:0] p2;
  logic                          s13_vld_q;
  logic [2:0][ssi_pkg::NUMW-1:0] s13_num_q;
  tail_t                         s13_tl_q;

  logic [2:0][ssi_pkg::NUMW-1:0] num_abs;
  logic                          s14_vld_q;
  logic [2:0][ssi_pkg::NMAGW-1:0] s14_mag_q;
  logic [2:0]                    s14_neg_q;
  tail_t                         s14_tl_q;

  // divider pipe
  logic [ssi_pkg::DENW-1:0]      den;
  logic [2:0]                    big;
  logic [ssi_pkg::DIV_STAGES-1:0] dv_vld_q;
  dv_side_t                      dv_side_q [ssi_pkg::DIV_STAGES];
  logic [2:0][ssi_pkg::QB-1:0]   dv_quo;
  logic [2:0]                    dv_nz;
  dv_side_t                      dv_out;

  // floor correction
  logic [2:0][ssi_pkg::QW-1:0]   q_up;
  logic                          sf_vld_q;
  logic [2:0][ssi_pkg::QW-1:0]   sf_q_q;
  dv_side_t                      sf_side_q;

  // saturation and output register
  logic [2:0][ssi_pkg::SUMW-1:0] hsum;
  logic [2:0][ssi_pkg::CW-1:0]   hit_d;
  logic [2:0]                    sat_d;
  logic                          done_q;
  logic [2:0][ssi_pkg::CW-1:0]   hit_q;
  ssi_pkg::status_e              st_q;
  logic                          sat_q;

  assign in_s = {start_z_i, start_y_i, start_x_i};
  assign in_e = {end_z_i, end_y_i, end_x_i};
  assign in_c = {center_z_i, center_y_i, center_x_i};

  // every cycle takes a new query
  assign busy = 1'b0;

  // valid bits, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      s13_vld_q <= 1'b0;
      s14_vld_q <= 1'b0;
      dv_vld_q  <= '0;
      sf_vld_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      s1_vld_q  <= start & ~busy;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      sq_vld_q  <= {sq_vld_q[ssi_pkg::SQ_STAGES-2:0], s6_vld_q};
      s7_vld_q  <= sq_vld_q[ssi_pkg::SQ_STAGES-1];
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= s10_vld_q;
      s12_vld_q <= s11_vld_q;
      s13_vld_q <= s12_vld_q;
      s14_vld_q <= s13_vld_q;
      dv_vld_q  <= {dv_vld_q[ssi_pkg::DIV_STAGES-2:0], s14_vld_q};
      sf_vld_q  <= dv_vld_q[ssi_pkg::DIV_STAGES-1];
      done_q    <= sf_vld_q;
    end
  end

  // stage 1: v = E - S, w = S - Q
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s1_s_q[k] <= in_s[k];
      s1_v_q[k] <= {in_e[k][ssi_pkg::CW-1], in_e[k]} - {in_s[k][ssi_pkg::CW-1], in_s[k]};
      s1_w_q[k] <= {in_s[k][ssi_pkg::CW-1], in_s[k]} - {in_c[k][ssi_pkg::CW-1], in_c[k]};
    end
    s1_r_q <= radius_i;
  end

  // stage 2: the nine coordinate products and r*r
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s2_vv_q[k] <= ssi_pkg::PRW'($signed(s1_v_q[k]) * $signed(s1_v_q[k]));
      s2_wv_q[k] <= ssi_pkg::PRW'($signed(s1_w_q[k]) * $signed(s1_v_q[k]));
      s2_ww_q[k] <= ssi_pkg::PRW'($signed(s1_w_q[k]) * $signed(s1_w_q[k]));
    end
    s2_rr_q <= ssi_pkg::RRW'(s1_r_q) * ssi_pkg::RRW'(s1_r_q);
    s2_s_q  <= s1_s_q;
    s2_v_q  <= s1_v_q;
  end

  // stage 3: A = v.v, b = w.v, C = w.w - r*r
  always_comb begin
    a_sum = (ssi_pkg::PRW+2)'($signed(s2_vv_q[0])) + (ssi_pkg::PRW+2)'($signed(s2_vv_q[1]))
          + (ssi_pkg::PRW+2)'($signed(s2_vv_q[2]));
    b_sum = (ssi_pkg::PRW+2)'($signed(s2_wv_q[0])) + (ssi_pkg::PRW+2)'($signed(s2_wv_q[1]))
          + (ssi_pkg::PRW+2)'($signed(s2_wv_q[2]));
    c_sum = (ssi_pkg::PRW+2)'($signed(s2_ww_q[0])) + (ssi_pkg::PRW+2)'($signed(s2_ww_q[1]))
          + (ssi_pkg::PRW+2)'($signed(s2_ww_q[2]))
          - $signed({{(ssi_pkg::PRW+2-ssi_pkg::RRW){1'b0}}, s2_rr_q});
  end

  always_ff @(posedge clk_i) begin
    s3_a_q <= a_sum[ssi_pkg::AW-1:0];
    s3_b_q <= b_sum[ssi_pkg::BW-1:0];
    s3_c_q <= c_sum[ssi_pkg::BW-1:0];
    s3_s_q <= s2_s_q;
    s3_v_q <= s2_v_q;
  end

  // stage 4: split magnitudes into halves for the wide products
  always_comb begin
    b_abs = s3_b_q[ssi_pkg::BW-1] ? (~s3_b_q + 1'b1) : s3_b_q;
    c_abs = s3_c_q[ssi_pkg::BW-1] ? (~s3_c_q + 1'b1) : s3_c_q;
    bm    = b_abs[ssi_pkg::MW-1:0];
    cm    = c_abs[ssi_pkg::MW-1:0];
    a_lo  = s3_a_q[ssi_pkg::HW-1:0];
    a_hi  = s3_a_q[ssi_pkg::MW-1:ssi_pkg::HW];
    b_lo  = bm[ssi_pkg::HW-1:0];
    b_hi  = bm[ssi_pkg::MW-1:ssi_pkg::HW];
    c_lo  = cm[ssi_pkg::HW-1:0];
    c_hi  = cm[ssi_pkg::MW-1:ssi_pkg::HW];
  end

  always_ff @(posedge clk_i) begin
    s4_bhh_q   <= ssi_pkg::PRW'(b_hi) * ssi_pkg::PRW'(b_hi);
    s4_bhl_q   <= ssi_pkg::PRW'(b_hi) * ssi_pkg::PRW'(b_lo);
    s4_bll_q   <= ssi_pkg::PRW'(b_lo) * ssi_pkg::PRW'(b_lo);
    s4_ahh_q   <= ssi_pkg::PRW'(a_hi) * ssi_pkg::PRW'(c_hi);
    s4_ahl_q   <= ssi_pkg::PRW'(a_hi) * ssi_pkg::PRW'(c_lo);
    s4_alh_q   <= ssi_pkg::PRW'(a_lo) * ssi_pkg::PRW'(c_hi);
    s4_all_q   <= ssi_pkg::PRW'(a_lo) * ssi_pkg::PRW'(c_lo);
    s4_cneg_q  <= s3_c_q[ssi_pkg::BW-1];
    s4_azero_q <= (s3_a_q == '0);
    s4_a_q     <= s3_a_q;
    s4_b_q     <= s3_b_q;
    s4_s_q     <= s3_s_q;
    s4_v_q     <= s3_v_q;
  end

  // stage 5: recombine the partial products
  always_ff @(posedge clk_i) begin
    s5_bsq_q   <= (ssi_pkg::SQW'(s4_bhh_q) << (2 * ssi_pkg::HW))
                + (ssi_pkg::SQW'(s4_bhl_q) << (ssi_pkg::HW + 1))
                + ssi_pkg::SQW'(s4_bll_q);
    s5_acm_q   <= (ssi_pkg::SQW'(s4_ahh_q) << (2 * ssi_pkg::HW))
                + ((ssi_pkg::SQW'(s4_ahl_q) + ssi_pkg::SQW'(s4_alh_q)) << ssi_pkg::HW)
                + ssi_pkg::SQW'(s4_all_q);
    s5_cneg_q  <= s4_cneg_q;
    s5_azero_q <= s4_azero_q;
    s5_a_q     <= s4_a_q;
    s5_b_q     <= s4_b_q;
    s5_s_q     <= s4_s_q;
    s5_v_q     <= s4_v_q;
  end

  // stage 6: quarter discriminant D = b*b - A*C and the case it selects
  always_comb begin
    if (s5_cneg_q) begin
      disc = ssi_pkg::DW'(s5_bsq_q) + ssi_pkg::DW'(s5_acm_q);
    end else begin
      disc = ssi_pkg::DW'(s5_bsq_q) - ssi_pkg::DW'(s5_acm_q);
    end
    // degenerate segment wins over the discriminant test
    priority if (s5_azero_q) begin
      st_d = ssi_pkg::ST_DEGEN;
    end else if (disc[ssi_pkg::DW-1]) begin
      st_d = ssi_pkg::ST_MISS;
    end else if (disc == '0) begin
      st_d = ssi_pkg::ST_TANGENT;
    end else begin
      st_d = ssi_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_rad_q     <= disc[ssi_pkg::DW-1] ? '0 : disc[ssi_pkg::SQW-1:0];
    s6_side_q.a  <= s5_a_q;
    s6_side_q.b  <= s5_b_q;
    s6_side_q.s  <= s5_s_q;
    s6_side_q.v  <= s5_v_q;
    s6_side_q.st <= st_d;
  end

  // square root of D; a zero D gives a zero root, so the tangent case
  // falls out of the two-root path with both roots equal
  ssi_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (s6_rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    sq_side_q[0] <= s6_side_q;
    for (int i = 1; i < ssi_pkg::SQ_STAGES; i++) begin
      sq_side_q[i] <= sq_side_q[i-1];
    end
  end

  assign sq_out = sq_side_q[ssi_pkg::SQ_STAGES-1];

  // stage 7: n1 = -b - sqrt(D), n2 = -b + sqrt(D)
  assign nb = ~{sq_out.b[ssi_pkg::BW-1], sq_out.b} + 1'b1;

  always_ff @(posedge clk_i) begin
    s7_n1_q    <= nb - ssi_pkg::NW'(root);
    s7_n2_q    <= nb + ssi_pkg::NW'(root);
    s7_tl_q.a  <= sq_out.a;
    s7_tl_q.s  <= sq_out.s;
    s7_tl_q.v  <= sq_out.v;
    s7_tl_q.st <= sq_out.st;
  end

  // stage 8: distances 2n - A of both roots from t = 0.5
  always_ff @(posedge clk_i) begin
    s8_d1_q <= {s7_n1_q[ssi_pkg::NW-1], s7_n1_q, 1'b0} - ssi_pkg::EW'(s7_tl_q.a);
    s8_d2_q <= {s7_n2_q[ssi_pkg::NW-1], s7_n2_q, 1'b0} - ssi_pkg::EW'(s7_tl_q.a);
    s8_n1_q <= s7_n1_q;
    s8_n2_q <= s7_n2_q;
    s8_tl_q <= s7_tl_q;
  end

  // stage 9: first root only when strictly nearer, ties go to the second
  always_comb begin
    e1 = s8_d1_q[ssi_pkg::EW-1] ? (~s8_d1_q + 1'b1) : s8_d1_q;
    e2 = s8_d2_q[ssi_pkg::EW-1] ? (~s8_d2_q + 1'b1) : s8_d2_q;
  end

  always_ff @(posedge clk_i) begin
    s9_n_q  <= (e1 < e2) ? s8_n1_q : s8_n2_q;
    s9_tl_q <= s8_tl_q;
  end

  // stage 10: sign and magnitude of n and of each v
  always_comb begin
    n_abs = s9_n_q[ssi_pkg::NW-1] ? (~s9_n_q + 1'b1) : s9_n_q;
    for (int k = 0; k < 3; k++) begin
      v_abs[k] = s9_tl_q.v[k][ssi_pkg::VW-1] ? (~s9_tl_q.v[k] + 1'b1) : s9_tl_q.v[k];
    end
  end

  always_ff @(posedge clk_i) begin
    s10_nm_q   <= n_abs[ssi_pkg::NMW-1:0];
    s10_nneg_q <= s9_n_q[ssi_pkg::NW-1];
    s10_vm_q   <= v_abs;
    for (int k = 0; k < 3; k++) begin
      s10_vneg_q[k] <= s9_tl_q.v[k][ssi_pkg::VW-1];
    end
    s10_tl_q   <= s9_tl_q;
  end

  // stage 11: |n|*|v| as two partial products per axis
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s11_pl_q[k]   <= ssi_pkg::PLW'(s10_nm_q[ssi_pkg::QB-1:0]) * ssi_pkg::PLW'(s10_vm_q[k]);
      s11_ph_q[k]   <= ssi_pkg::PHW'(s10_nm_q[ssi_pkg::NMW-1:ssi_pkg::QB])
                     * ssi_pkg::PHW'(s10_vm_q[k]);
      s11_pneg_q[k] <= s10_nneg_q ^ s10_vneg_q[k];
    end
    s11_tl_q <= s10_tl_q;
  end

  // stage 12: |n*v|
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s12_pm_q[k] <= {s11_ph_q[k][ssi_pkg::PMW-ssi_pkg::QB-1:0], {ssi_pkg::QB{1'b0}}}
                   + ssi_pkg::PMW'(s11_pl_q[k]);
    end
    s12_pneg_q <= s11_pneg_q;
    s12_tl_q   <= s11_tl_q;
  end

  // stage 13: num = 2*n*v + A
  always_comb begin
    a_ext = ssi_pkg::NUMW'(s12_tl_q.a);
    for (int k = 0; k < 3; k++) begin
      p2[k] = {2'b00, s12_pm_q[k], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s13_num_q[k] <= s12_pneg_q[k] ? (a_ext - p2[k]) : (a_ext + p2[k]);
    end
    s13_tl_q <= s12_tl_q;
  end

  // stage 14: sign and magnitude of the numerator
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_abs[k] = s13_num_q[k][ssi_pkg::NUMW-1] ? (~s13_num_q[k] + 1'b1) : s13_num_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s14_mag_q[k] <= num_abs[k][ssi_pkg::NMAGW-1:0];
      s14_neg_q[k] <= s13_num_q[k][ssi_pkg::NUMW-1];
    end
    s14_tl_q <= s13_tl_q;
  end

  // divide |num| by 2A; a quotient past the window always saturates, so only
  // its low bits are resolved and the overflow is flagged alongside
  assign den = {s14_tl_q.a, 1'b0};

  for (genvar k = 0; k < 3; k++) begin : g_div
    assign big[k] = (s14_mag_q[k][ssi_pkg::NMAGW-1:ssi_pkg::QB] >= den);

    ssi_div u_div (
      .clk_i    (clk_i),
      .num_hi_i (s14_mag_q[k][ssi_pkg::NMAGW-1:ssi_pkg::QB]),
      .num_lo_i (s14_mag_q[k][ssi_pkg::QB-1:0]),
      .den_i    (den),
      .quo_o    (dv_quo[k]),
      .rem_nz_o (dv_nz[k])
    );
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0].s   <= s14_tl_q.s;
    dv_side_q[0].st  <= s14_tl_q.st;
    dv_side_q[0].neg <= s14_neg_q;
    dv_side_q[0].big <= big;
    for (int i = 1; i < ssi_pkg::DIV_STAGES; i++) begin
      dv_side_q[i] <= dv_side_q[i-1];
    end
  end

  assign dv_out = dv_side_q[ssi_pkg::DIV_STAGES-1];

  // floor of a negative quotient: one further down when a remainder is left
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_up[k] = ssi_pkg::QW'(dv_quo[k]) + ssi_pkg::QW'(dv_nz[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sf_q_q[k] <= dv_out.neg[k] ? (~q_up[k] + 1'b1) : ssi_pkg::QW'(dv_quo[k]);
    end
    sf_side_q <= dv_out;
  end

  // hit = S + t*v, clamped; miss and degenerate give zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hsum[k] = {{(ssi_pkg::SUMW-ssi_pkg::CW){sf_side_q.s[k][ssi_pkg::CW-1]}}, sf_side_q.s[k]}
              + {sf_q_q[k][ssi_pkg::QW-1], sf_q_q[k]};
      hit_d[k] = '0;
      sat_d[k] = 1'b0;
      if (sf_side_q.st == ssi_pkg::ST_TANGENT || sf_side_q.st == ssi_pkg::ST_TWO) begin
        priority if (sf_side_q.big[k]) begin
          hit_d[k] = sf_side_q.neg[k] ? ssi_pkg::CMIN : ssi_pkg::CMAX;
          sat_d[k] = 1'b1;
        end else if ((|hsum[k][ssi_pkg::SUMW-1:ssi_pkg::CW-1])
                     && !(&hsum[k][ssi_pkg::SUMW-1:ssi_pkg::CW-1])) begin
          hit_d[k] = hsum[k][ssi_pkg::SUMW-1] ? ssi_pkg::CMIN : ssi_pkg::CMAX;
          sat_d[k] = 1'b1;
        end else begin
          hit_d[k] = hsum[k][ssi_pkg::CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    st_q  <= sf_side_q.st;
    sat_q <= |sat_d;
  end

  assign done_o      = done_q;
  assign hit_x_o     = hit_q[0];
  assign hit_y_o     = hit_q[1];
  assign hit_z_o     = hit_q[2];
  assign status_o    = st_q;
  assign saturated_o = sat_q;

endmodule

>>> dv/ssi_checker.sv
`timescale 1ns / 1ps

module ssi_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [ssi_pkg::CW-1:0]   start_x_i,
  input  logic signed [ssi_pkg::CW-1:0]   start_y_i,
  input  logic signed [ssi_pkg::CW-1:0]   start_z_i,
  input  logic signed [ssi_pkg::CW-1:0]   end_x_i,
  input  logic signed [ssi_pkg::CW-1:0]   end_y_i,
  input  logic signed [ssi_pkg::CW-1:0]   end_z_i,
  input  logic signed [ssi_pkg::CW-1:0]   center_x_i,
  input  logic signed [ssi_pkg::CW-1:0]   center_y_i,
  input  logic signed [ssi_pkg::CW-1:0]   center_z_i,
  input  logic        [ssi_pkg::RADW-1:0] radius_i,
  input  logic                            done_o,
  input  logic signed [ssi_pkg::CW-1:0]   hit_x_o,
  input  logic signed [ssi_pkg::CW-1:0]   hit_y_o,
  input  logic signed [ssi_pkg::CW-1:0]   hit_z_o,
  input  logic        [1:0]               status_o,
  input  logic                            saturated_o,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef logic signed [255:0] big_t;

  localparam big_t PT_MAX = big_t'($signed(ssi_pkg::CMAX));
  localparam big_t PT_MIN = big_t'($signed(ssi_pkg::CMIN));

  typedef struct {
    logic signed [ssi_pkg::CW-1:0] x;
    logic signed [ssi_pkg::CW-1:0] y;
    logic signed [ssi_pkg::CW-1:0] z;
    ssi_pkg::status_e              status;
    logic                          sat;
  } hit_t;

  hit_t hits_due[$];
  int   fails = 0;
  int   pending_q = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_q;

  // exact quadratic solve, point nearest the segment midpoint
  function automatic hit_t solve_hit(input big_t s[3], input big_t e[3], input big_t q[3],
                                     input big_t rad);
    hit_t h;
    big_t v[3], w[3];
    big_t a, b, c, d, root, n, n1, n2, e1, e2, num, den, quo, pt;
    a = 0; b = 0; c = 0;
    h.x = '0; h.y = '0; h.z = '0; h.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      v[k] = e[k] - s[k];
      w[k] = s[k] - q[k];
      a += v[k] * v[k];
      b += w[k] * v[k];
      c += w[k] * w[k];
    end
    c -= rad * rad;
    d = b * b - a * c;
    if (a == 0) begin
      h.status = ssi_pkg::ST_DEGEN;
      return h;
    end
    if (d < 0) begin
      h.status = ssi_pkg::ST_MISS;
      return h;
    end
    if (d == 0) begin
      n = -b;
      h.status = ssi_pkg::ST_TANGENT;
    end else begin
      root = 0;
      for (int bt = 90; bt >= 0; bt--) begin
        big_t t;
        t = root | (big_t'(1) <<< bt);
        if (t * t <= d) root = t;
      end
      n1 = -b - root;
      n2 = -b + root;
      e1 = 2 * n1 - a; if (e1 < 0) e1 = -e1;
      e2 = 2 * n2 - a; if (e2 < 0) e2 = -e2;
      n = (e1 < e2) ? n1 : n2;
      h.status = ssi_pkg::ST_TWO;
    end
    den = 2 * a;
    for (int k = 0; k < 3; k++) begin
      num = 2 * n * v[k] + a;
      quo = num / den;
      if (num < 0 && quo * den != num) quo -= 1;   // floor
      pt = s[k] + quo;
      if (pt > PT_MAX) begin
        pt = PT_MAX; h.sat = 1'b1;
      end else if (pt < PT_MIN) begin
        pt = PT_MIN; h.sat = 1'b1;
      end
      if (k == 0) h.x = pt[ssi_pkg::CW-1:0];
      else if (k == 1) h.y = pt[ssi_pkg::CW-1:0];
      else h.z = pt[ssi_pkg::CW-1:0];
    end
    return h;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    big_t s[3], e[3], q[3];
    hit_t h;
    if (rst_ni && start && !busy) begin
      s[0] = start_x_i; s[1] = start_y_i; s[2] = start_z_i;
      e[0] = end_x_i;   e[1] = end_y_i;   e[2] = end_z_i;
      q[0] = center_x_i; q[1] = center_y_i; q[2] = center_z_i;
      hits_due.push_back(solve_hit(s, e, q, big_t'({1'b0, radius_i})));
    end
    if (rst_ni && done_o) begin
      if (hits_due.size() == 0) begin
        report_mismatch("unexpected beat", 64'd1, 64'd0);
      end else begin
        h = hits_due.pop_front();
        if (hit_x_o !== h.x) report_mismatch("hit_x", 64'(hit_x_o), 64'(h.x));
        if (hit_y_o !== h.y) report_mismatch("hit_y", 64'(hit_y_o), 64'(h.y));
        if (hit_z_o !== h.z) report_mismatch("hit_z", 64'(hit_z_o), 64'(h.z));
        if (status_o !== h.status) begin
          report_mismatch("status", 64'(status_o), 64'(h.status));
        end
        if (saturated_o !== h.sat) begin
          report_mismatch("saturated", 64'(saturated_o), 64'(h.sat));
        end
      end
    end
    pending_q <= hits_due.size();
  end

endmodule

>>> dv/segment_sphere_intersection_test.sv
`timescale 1ns / 1ps

module segment_sphere_intersection_test;

  localparam int N_RANDOM = 530;
  localparam int LIMIT    = 200000;   // cycles, far beyond the slowest legal run
  localparam int DRAIN    = 200;      // pipeline is 116 deep
  localparam int CW       = ssi_pkg::CW;
  localparam int RADW     = ssi_pkg::RADW;

  localparam logic signed [CW-1:0] PMAX = ssi_pkg::CMAX;
  localparam logic signed [CW-1:0] PMIN = ssi_pkg::CMIN;
  localparam logic [RADW-1:0]      RMAX = ssi_pkg::CMAX[RADW-1:0];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [CW-1:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic signed [CW-1:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [RADW-1:0] radius_i = '0;
  logic done_o;
  logic signed [CW-1:0] hit_x_o, hit_y_o, hit_z_o;
  logic [1:0] status_o;
  logic saturated_o;
  int fail_count, pending;
  int cycles = 0;
  int burst_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_sphere_intersection u_dut (.*);

  // watches both channels, predicts every beat and compares
  ssi_checker u_checker (
    .clk_i, .rst_ni, .start, .busy,
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .center_x_i, .center_y_i, .center_z_i, .radius_i,
    .done_o, .hit_x_o, .hit_y_o, .hit_z_o, .status_o, .saturated_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // present one query and hold it until the block takes it
  task automatic send_query(input logic signed [CW-1:0] sx, sy, sz, ex, ey, ez,
                            input logic signed [CW-1:0] qx, qy, qz,
                            input logic [RADW-1:0] rad);
    start     <= 1'b1;
    start_x_i <= sx;  start_y_i <= sy;  start_z_i <= sz;
    end_x_i   <= ex;  end_y_i   <= ey;  end_z_i   <= ez;
    center_x_i <= qx; center_y_i <= qy; center_z_i <= qz;
    radius_i  <= rad;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    // bursty sender: after a burst, drop start for a random gap unless the gap drawn is zero
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  function automatic logic signed [CW-1:0] near(input int base, input int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    int a, r, c0, c1, c2, sel, span;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: degenerate segments, extremes, miss, tangent, two roots, clamping
    send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_query(PMAX, PMIN, PMAX, PMAX, PMIN, PMAX, 0, 0, 0, RMAX);
    send_query(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, PMIN, PMAX, PMIN, RMAX);
    send_query(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMAX, PMIN, PMAX, '0);
    send_query(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 0, 0, 0, '0);
    send_query(PMIN, 0, 0, PMAX, 0, 0, 0, 0, 0, RMAX);
    send_query(-100, 50, 0, 100, 50, 0, 0, 0, 0, 50);      // tangent
    send_query(-100, 51, 0, 100, 51, 0, 0, 0, 0, 50);      // just missing
    send_query(-100, 49, 0, 100, 49, 0, 0, 0, 0, 50);      // two close roots
    send_query(0, 0, 0, 0, 0, 65536, 0, 0, 0, 65536 / 2);  // hit inside segment
    send_query(-1, 0, 0, 1, 0, 0, 0, 0, 0, 1);             // midpoint tie
    send_query(PMAX, 0, 0, PMAX - 1, 0, 0, PMAX, 0, 0, RMAX);
    send_query(PMIN, 0, 0, PMIN + 1, 0, 0, PMIN, 0, 0, RMAX);
    send_query(0, PMAX, 0, 0, PMAX - 1, 0, 0, PMIN, 0, 3);
    send_query(0, 0, PMIN, 0, 0, PMIN + 1, 0, 0, PMAX, 5);
    send_query(5, 5, 5, 5, 5, 5, 0, 0, 0, 100);            // degenerate inside sphere
    send_query(0, 0, 0, 1, 1, 1, 0, 0, 0, RMAX);
    send_query(10, -20, 30, 10, -20, 31, 10, -20, 30, 0);  // zero radius at start

    for (int i = 0; i < N_RANDOM; i++) begin
      sel  = $urandom_range(0, 9);
      span = 1 << $urandom_range(2, 24);
      c0 = $urandom; c1 = $urandom; c2 = $urandom;
      if (sel <= 4) begin
        // well formed: segment around a sphere at a random place
        c0 = c0 >>> 6; c1 = c1 >>> 6; c2 = c2 >>> 6;
        send_query(near(c0, span), near(c1, span), near(c2, span),
                   near(c0, span), near(c1, span), near(c2, span),
                   c0, c1, c2, RADW'($urandom_range(0, span)));
      end else if (sel == 5) begin
        send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, RADW'($urandom));
      end else if (sel == 6) begin
        send_query(c0, c1, c2, c0, c1, c2, $urandom, $urandom, $urandom, RADW'($urandom));
      end else if (sel == 7) begin
        // tangent: line offset from the center by exactly the radius
        a = $urandom_range(1, 1 << 20);
        r = $urandom_range(0, 1 << 20);
        c0 = c0 >>> 4; c1 = c1 >>> 4; c2 = c2 >>> 4;
        send_query(c0 - a, c1 + r, c2, c0 + a, c1 + r, c2, c0, c1, c2, RADW'(r));
      end else begin
        // near the edges of the range, radius large
        send_query(near(PMAX, span), near(PMIN, span), $urandom,
                   near(PMAX, span), near(PMIN, span), $urandom,
                   near(0, span), $urandom, near(PMIN, span),
                   RADW'(RMAX - $urandom_range(0, span)));
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
